### rtl/eqpd_pkg.sv
// Shared types, constants and weight table for the error queue palette ditherer.
`default_nettype none

package eqpd_pkg;

	localparam int HIST_LEN     = 16;
	localparam int WEIGHT_RATIO = 16;
	localparam int PAL_DEPTH    = 256;
	localparam int COLOR_BITS   = 16;

	localparam int HIST_IDX_W = $clog2(HIST_LEN);
	localparam int PAL_ADDR_W = $clog2(PAL_DEPTH);
	localparam int CNT_W      = $clog2(PAL_DEPTH + 1);
	localparam int ERR_W      = COLOR_BITS + 2;
	localparam int W_W        = 17;
	localparam int W_FRAC     = 16;
	localparam int RATIO_FRAC = 20;
	localparam int CORR_W     = COLOR_BITS + 5;
	localparam int MUL_W      = 20;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int DIST_W     = 58;
	localparam int ACC_W      = DIST_W + 1;
	localparam int LUMA_W     = 16;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_DITHER = 1'b1;

	typedef logic [2:0][COLOR_BITS-1:0] rgb_t;
	typedef logic [HIST_LEN-1:0][W_W-1:0] weight_rom_t;

	localparam logic [2:0][LUMA_W-1:0] LUMA = {16'd3886, 16'd44433, 16'd17216};

	typedef enum logic [1:0] {
		ACC_NONE,
		ACC_LOAD,
		ACC_ADD,
		ACC_ADD_HI
	} acc_mode_t;

	typedef struct packed {
		acc_mode_t        mode;
		logic             neg;
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
	} mac_op_t;

	function automatic logic power_fits(input logic [63:0] m, input logic [63:0] target);
		logic [63:0] p;
		logic        ok;
		p  = 64'd1 << RATIO_FRAC;
		ok = 1'b1;
		for (int k = 0; k < HIST_LEN - 1; k++) begin
			p = (p * m) >> RATIO_FRAC;
			if (p > target)
				ok = 1'b0;
		end
		return ok;
	endfunction

	function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], num[i]};
			if (r >= {1'b0, den}) begin
				r    = r - {1'b0, den};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic weight_rom_t build_weights();
		logic [63:0] target;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		logic [63:0] w;
		weight_rom_t rom;
		target = 64'(WEIGHT_RATIO) << RATIO_FRAC;
		lo     = 64'd1 << RATIO_FRAC;
		hi     = target;
		for (int it = 0; it < 64; it++) begin
			if (lo < hi) begin
				mid = lo + ((hi - lo + 64'd1) >> 1);
				if (power_fits(mid, target))
					lo = mid;
				else
					hi = mid - 64'd1;
			end
		end
		w = 64'd1 << W_FRAC;
		rom[HIST_LEN-1] = W_W'(w);
		for (int i = HIST_LEN - 2; i >= 0; i--) begin
			w = udiv((w << RATIO_FRAC) + (lo >> 1), lo);
			rom[i] = W_W'(w);
		end
		return rom;
	endfunction

	localparam weight_rom_t WEIGHT_ROM = build_weights();

endpackage

`default_nettype wire

### rtl/eqpd_if.sv
// Channel interfaces: configuration, input items and result items.
`default_nettype none

interface eqpd_cfg_if import eqpd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] palette_entries;

	modport source (output valid, output palette_entries, input ready);
	modport sink (input valid, input palette_entries, output ready);
endinterface

interface eqpd_cmd_if import eqpd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  action;
	logic [PAL_ADDR_W-1:0] entry_number;
	logic [COLOR_BITS-1:0] red;
	logic [COLOR_BITS-1:0] green;
	logic [COLOR_BITS-1:0] blue;
	logic                  first_pixel;

	modport source (output valid, output action, output entry_number, output red,
		output green, output blue, output first_pixel, input ready);
	modport sink (input valid, input action, input entry_number, input red,
		input green, input blue, input first_pixel, output ready);
endinterface

interface eqpd_res_if import eqpd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [PAL_ADDR_W-1:0] chosen_entry;
	logic [COLOR_BITS-1:0] out_red;
	logic [COLOR_BITS-1:0] out_green;
	logic [COLOR_BITS-1:0] out_blue;

	modport source (output valid, output chosen_entry, output out_red,
		output out_green, output out_blue, input ready);
	modport sink (input valid, input chosen_entry, input out_red,
		input out_green, input out_blue, output ready);
endinterface

`default_nettype wire

### rtl/eqpd_mac.sv
// Shared multiplier with registered product and signed accumulator.
`default_nettype none

module eqpd_mac import eqpd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mac_op_t                  op,
	output logic [PROD_W-1:0]        prod,
	output logic signed [ACC_W-1:0] acc
);

	acc_mode_t               mode_q;
	logic                    neg_q;
	logic [PROD_W-1:0]       prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] prod_ext;
	logic signed [ACC_W-1:0] term;

	assign prod_ext = $signed({{(ACC_W-PROD_W){1'b0}}, prod_q});
	assign term     = neg_q ? -prod_ext : prod_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ACC_NONE;
			neg_q  <= 1'b0;
		end else begin
			mode_q <= op.mode;
			neg_q  <= op.neg;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= op.a * op.b;
		case (mode_q)
			ACC_LOAD:   acc_q <= term;
			ACC_ADD:    acc_q <= acc_q + term;
			ACC_ADD_HI: acc_q <= acc_q + (prod_ext <<< MUL_W);
			default: ;
		endcase
	end

	assign prod = prod_q;
	assign acc  = acc_q;

endmodule

`default_nettype wire

### rtl/error_queue_palette_dither_top.sv
// Top level of the error queue palette ditherer: sequencer, palette memory, history.
//
//  channel | role   | carries
//  --------+--------+----------------------------------------------------------
//  cfg     | sink   | palette_entries, number of entries searched
//  cmd     | sink   | action, entry_number, red, green, blue, first_pixel
//  res     | source | chosen_entry, out_red, out_green, out_blue
//
//  For a pixel, one multiplier serves the error sum with one product per history term
//  and channel, then the palette search with nine products per palette entry.
//  Reset clears the error history; the palette memory is undefined until loaded.
//  cmd is ready only while idle; res holds its item until taken, and a new item
//  may be accepted meanwhile. cfg is always ready.
`default_nettype none

module error_queue_palette_dither_top import eqpd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	eqpd_cfg_if.sink   cfg,
	eqpd_cmd_if.sink   cmd,
	eqpd_res_if.source res
);

	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_READ = 4'd0;
	localparam logic [STEP_W-1:0] STEP_DIFF = 4'd1;
	localparam logic [STEP_W-1:0] STEP_SQ0  = 4'd2;
	localparam logic [STEP_W-1:0] STEP_LO0  = 4'd3;
	localparam logic [STEP_W-1:0] STEP_HI0  = 4'd4;
	localparam logic [STEP_W-1:0] STEP_SQ1  = 4'd5;
	localparam logic [STEP_W-1:0] STEP_LO1  = 4'd6;
	localparam logic [STEP_W-1:0] STEP_HI1  = 4'd7;
	localparam logic [STEP_W-1:0] STEP_SQ2  = 4'd8;
	localparam logic [STEP_W-1:0] STEP_LO2  = 4'd9;
	localparam logic [STEP_W-1:0] STEP_HI2  = 4'd10;
	localparam logic [STEP_W-1:0] STEP_LAST = 4'd11;
	localparam logic [1:0] CH_RED  = 2'd0;
	localparam logic [1:0] CH_GRN  = 2'd1;
	localparam logic [1:0] CH_BLU  = 2'd2;
	localparam logic [HIST_IDX_W-1:0] HIDX_LAST = HIST_IDX_W'(HIST_LEN - 1);
	localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) <<< (W_FRAC - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_HIST,
		S_SEARCH,
		S_PICK,
		S_DONE
	} state_t;

	typedef logic signed [ERR_W-1:0] err_t;
	typedef logic signed [CORR_W-1:0] corr_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        entries_q;
	logic [PAL_ADDR_W-1:0]   last_q;
	logic [PAL_ADDR_W-1:0]   ent_q;
	logic [STEP_W-1:0]       step_q;
	logic [HIST_IDX_W-1:0]   hidx_q;
	logic [1:0]              chan_q;
	logic                    iss_done_q;
	logic                    last_s1;
	logic                    last_s2;
	logic [1:0]              chan_s1;
	logic [1:0]              chan_s2;
	logic                    out_valid_q;

	err_t                    hist_q [HIST_LEN][3];
	rgb_t                    pal_mem [PAL_DEPTH];
	rgb_t                    rd_q;
	rgb_t                    pix_q;
	corr_t                   corr_q [3];
	logic [MUL_W-1:0]        ad_q [3];
	logic [MUL_W-1:0]        hold_q;
	logic [PAL_ADDR_W-1:0]   best_idx_q;
	logic [DIST_W-1:0]       best_dist_q;
	rgb_t                    best_col_q;
	logic [PAL_ADDR_W-1:0]   out_idx_q;
	rgb_t                    out_col_q;

	logic                    cmd_fire;
	logic                    out_free;
	logic                    done_fire;
	logic                    rd_en;
	rgb_t                    col_in;
	logic [PAL_ADDR_W-1:0]   last_new;
	err_t                    hist_rd;
	logic [ERR_W-1:0]        hist_mag;
	logic [1:0]              sch;
	mac_op_t                 op;
	logic [PROD_W-1:0]       prod;
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] rnd_sum;
	logic signed [ACC_W-1:0] rnd_sh;
	corr_t                   corr_new;
	logic [MUL_W-1:0]        ad_new [3];
	err_t                    err_new [3];
	logic                    cmp_en;
	logic [PAL_ADDR_W-1:0]   cmp_idx;
	logic                    take;

	eqpd_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.prod   (prod),
		.acc    (acc)
	);

	assign cmd.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign out_free  = !out_valid_q || res.ready;
	assign done_fire = (state_q == S_DONE) && out_free;
	assign rd_en     = (state_q == S_SEARCH) && (step_q == STEP_READ);

	assign col_in[CH_RED] = cmd.red;
	assign col_in[CH_GRN] = cmd.green;
	assign col_in[CH_BLU] = cmd.blue;

	always_comb begin
		if (entries_q == '0)
			last_new = '0;
		else if (entries_q > CNT_W'(PAL_DEPTH))
			last_new = PAL_ADDR_W'(PAL_DEPTH - 1);
		else
			last_new = PAL_ADDR_W'(entries_q - 1'b1);
	end

	assign hist_rd  = hist_q[hidx_q][chan_q];
	assign hist_mag = hist_rd[ERR_W-1] ? ERR_W'(-hist_rd) : ERR_W'(hist_rd);

	always_comb begin
		case (step_q)
			STEP_SQ1, STEP_LO1, STEP_HI1: sch = CH_GRN;
			STEP_SQ2, STEP_LO2, STEP_HI2: sch = CH_BLU;
			default:                      sch = CH_RED;
		endcase
	end

	always_comb begin
		op.mode = ACC_NONE;
		op.neg  = 1'b0;
		op.a    = '0;
		op.b    = '0;
		case (state_q)
			S_HIST: begin
				if (!iss_done_q) begin
					op.mode = (hidx_q == '0) ? ACC_LOAD : ACC_ADD;
					op.neg  = hist_rd[ERR_W-1];
					op.a    = MUL_W'(hist_mag);
					op.b    = MUL_W'(WEIGHT_ROM[hidx_q]);
				end
			end
			S_SEARCH: begin
				case (step_q)
					STEP_SQ0, STEP_SQ1, STEP_SQ2: begin
						op.a = ad_q[sch];
						op.b = ad_q[sch];
					end
					STEP_LO0, STEP_LO1, STEP_LO2: begin
						op.mode = (step_q == STEP_LO0) ? ACC_LOAD : ACC_ADD;
						op.a    = prod[MUL_W-1:0];
						op.b    = MUL_W'(LUMA[sch]);
					end
					STEP_HI0, STEP_HI1, STEP_HI2: begin
						op.mode = ACC_ADD_HI;
						op.a    = hold_q;
						op.b    = MUL_W'(LUMA[sch]);
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	assign rnd_sum  = acc + ROUND;
	assign rnd_sh   = rnd_sum >>> W_FRAC;
	assign corr_new = rnd_sh[CORR_W-1:0] + {{(CORR_W-COLOR_BITS){1'b0}}, pix_q[chan_s2]};

	always_comb begin
		corr_t diff;
		for (int c = 0; c < 3; c++) begin
			diff      = corr_q[c] - $signed({{(CORR_W-COLOR_BITS){1'b0}}, rd_q[c]});
			diff      = diff[CORR_W-1] ? -diff : diff;
			ad_new[c] = diff[MUL_W-1:0];
			err_new[c] = $signed({2'b00, pix_q[c]}) - $signed({2'b00, best_col_q[c]});
		end
	end

	assign cmp_en  = ((state_q == S_SEARCH) && (step_q == STEP_READ) && (ent_q != '0))
		|| (state_q == S_PICK);
	assign cmp_idx = (state_q == S_PICK) ? ent_q : ent_q - 1'b1;
	assign take    = (cmp_idx == '0) || (acc[DIST_W-1:0] < best_dist_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			entries_q   <= CNT_W'(PAL_DEPTH);
			last_q      <= '0;
			ent_q       <= '0;
			step_q      <= '0;
			hidx_q      <= '0;
			chan_q      <= '0;
			iss_done_q  <= 1'b0;
			last_s1     <= 1'b0;
			last_s2     <= 1'b0;
			chan_s1     <= '0;
			chan_s2     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid)
				entries_q <= cfg.palette_entries;
			if (res.valid && res.ready)
				out_valid_q <= 1'b0;
			last_s1 <= 1'b0;
			last_s2 <= last_s1;
			chan_s2 <= chan_s1;
			case (state_q)
				S_IDLE: begin
					if (cmd_fire && (cmd.action == ACT_DITHER)) begin
						state_q    <= S_HIST;
						hidx_q     <= '0;
						chan_q     <= CH_RED;
						iss_done_q <= 1'b0;
						last_q     <= last_new;
					end
				end
				S_HIST: begin
					if (!iss_done_q) begin
						if (hidx_q == HIDX_LAST) begin
							hidx_q  <= '0;
							last_s1 <= 1'b1;
							chan_s1 <= chan_q;
							if (chan_q == CH_BLU)
								iss_done_q <= 1'b1;
							else
								chan_q <= chan_q + 1'b1;
						end else begin
							hidx_q <= hidx_q + 1'b1;
						end
					end
					if (last_s2 && (chan_s2 == CH_BLU)) begin
						state_q <= S_SEARCH;
						step_q  <= STEP_READ;
						ent_q   <= '0;
					end
				end
				S_SEARCH: begin
					if (step_q == STEP_LAST) begin
						step_q <= STEP_READ;
						if (ent_q == last_q)
							state_q <= S_PICK;
						else
							ent_q <= ent_q + 1'b1;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_PICK: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_LEN; i++)
				for (int c = 0; c < 3; c++)
					hist_q[i][c] <= '0;
		end else if (cmd_fire && (cmd.action == ACT_DITHER) && cmd.first_pixel) begin
			for (int i = 0; i < HIST_LEN; i++)
				for (int c = 0; c < 3; c++)
					hist_q[i][c] <= '0;
		end else if (done_fire) begin
			for (int i = 0; i < HIST_LEN - 1; i++)
				hist_q[i] <= hist_q[i+1];
			for (int c = 0; c < 3; c++)
				hist_q[HIST_LEN-1][c] <= err_new[c];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire && (cmd.action == ACT_LOAD))
			pal_mem[cmd.entry_number] <= col_in;
		if (rd_en)
			rd_q <= pal_mem[ent_q];
	end

	always_ff @(posedge clk) begin
		if (cmd_fire)
			pix_q <= col_in;
		if (last_s2)
			corr_q[chan_s2] <= corr_new;
		if ((state_q == S_SEARCH) && (step_q == STEP_DIFF))
			for (int c = 0; c < 3; c++)
				ad_q[c] <= ad_new[c];
		if ((state_q == S_SEARCH)
			&& ((step_q == STEP_LO0) || (step_q == STEP_LO1) || (step_q == STEP_LO2)))
			hold_q <= prod[PROD_W-1:MUL_W];
		if (cmp_en && take) begin
			best_idx_q  <= cmp_idx;
			best_dist_q <= acc[DIST_W-1:0];
			best_col_q  <= rd_q;
		end
		if (done_fire) begin
			out_idx_q <= best_idx_q;
			out_col_q <= best_col_q;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.chosen_entry = out_idx_q;
	assign res.out_red      = out_col_q[CH_RED];
	assign res.out_green    = out_col_q[CH_GRN];
	assign res.out_blue     = out_col_q[CH_BLU];

endmodule

`default_nettype wire
